[rtl/ldd_pkg.sv]
package ldd_pkg;

   localparam logic [7:0]  START_BYTE  = 8'hF4;
   localparam logic [7:0]  END_BYTE    = 8'hF5;
   localparam logic [16:0] ECHO_POS    = 17'd6;
   localparam logic [15:0] LIMIT_RESET = 16'd3000;
   localparam logic [7:0]  STALL_RESET = 8'd10;
   localparam int          QUEUE_DEPTH = 4;
   localparam int          QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_GOOD = 2'd1,
      KIND_DROP = 2'd2
   } kind_type;

   typedef enum logic {
      REG_LENGTH_LIMIT = 1'b0,
      REG_STALL_LIMIT  = 1'b1
   } reg_index_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [16:0] frame_length;
   } result_type;

   typedef struct packed {
      logic       pair;
      result_type first;
      result_type second;
   } entry_type;

   typedef struct packed {
      logic [15:0] length_limit;
      logic [7:0]  stall_limit;
   } cfg_type;

   function automatic result_type make_data(input logic [7:0] b);
      result_type r;
      r.kind         = KIND_DATA;
      r.data_byte    = b;
      r.frame_length = '0;
      return r;
   endfunction

   function automatic result_type make_good(input logic [16:0] len);
      result_type r;
      r.kind         = KIND_GOOD;
      r.data_byte    = '0;
      r.frame_length = len;
      return r;
   endfunction

   function automatic result_type make_drop();
      result_type r;
      r.kind         = KIND_DROP;
      r.data_byte    = '0;
      r.frame_length = '0;
      return r;
   endfunction

endpackage

[rtl/ldd_front.sv]
module ldd_front (
   input  logic              clock,
   input  logic              reset,
   input  ldd_pkg::cfg_type  cfg,
   input  logic              accept,
   input  logic              opcode,
   input  logic [7:0]        rx_byte,
   output logic              entry_push,
   output ldd_pkg::entry_type entry
);
   import ldd_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_LEN_HI  = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_PAYLOAD = 3'd3,
      PH_END     = 3'd4,
      PH_BAD5    = 3'd5,
      PH_BAD6    = 3'd6,
      PH_BAD7    = 3'd7
   } phase_type;

   phase_type   phase_ff, phase_in, prev_phase_ff, prev_phase_in;
   logic [7:0]  length_high_ff, length_high_in, length_low_ff, length_low_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [16:0] stored_ff, stored_in;
   logic [7:0]  stall_ff, stall_in;
   logic        echo_bad_ff, echo_bad_in;
   logic        has_result;
   logic [7:0]  stall_inc;

   assign stall_inc = (stall_ff == 8'hFF) ? stall_ff : stall_ff + 8'd1;

   always_comb begin
      phase_in       = phase_ff;
      prev_phase_in  = prev_phase_ff;
      length_high_in = length_high_ff;
      length_low_in  = length_low_ff;
      remaining_in   = remaining_ff;
      stored_in      = stored_ff;
      stall_in       = stall_ff;
      echo_bad_in    = echo_bad_ff;
      has_result     = 1'b0;
      entry.pair     = 1'b0;
      entry.first    = make_drop();
      entry.second   = make_drop();
      if (opcode) begin
         if (phase_ff != PH_HUNT && phase_ff == prev_phase_ff) begin
            stall_in = stall_inc;
            if (stall_inc > cfg.stall_limit) begin
               phase_in    = PH_HUNT;
               stored_in   = '0;
               echo_bad_in = 1'b0;
               has_result  = 1'b1;
            end
         end else begin
            stall_in      = '0;
            prev_phase_in = phase_ff;
         end
      end else begin
         case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == START_BYTE) phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_high_in = rx_byte;
               phase_in       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               length_low_in = rx_byte;
               remaining_in  = {length_high_ff, rx_byte};
               stored_in     = 17'd2;
               echo_bad_in   = 1'b0;
               phase_in      = PH_PAYLOAD;
               has_result    = 1'b1;
               entry.pair    = 1'b1;
               entry.first   = make_data(length_high_ff);
               entry.second  = make_data(rx_byte);
            end
            PH_PAYLOAD: begin
               has_result = 1'b1;
               if (remaining_ff != '0 && remaining_ff < cfg.length_limit) begin
                  remaining_in = remaining_ff - 16'd1;
                  stored_in    = stored_ff + 17'd1;
                  entry.first  = make_data(rx_byte);
                  if (remaining_ff == 16'd1) phase_in = PH_END;
                  if (stored_in == ECHO_POS - 17'd1) echo_bad_in = (rx_byte != length_high_ff);
                  if (stored_in == ECHO_POS && (echo_bad_ff || rx_byte != length_low_ff)) begin
                     phase_in    = PH_HUNT;
                     stored_in   = '0;
                     echo_bad_in = 1'b0;
                     entry.pair  = 1'b1;
                  end
               end else begin
                  phase_in    = PH_HUNT;
                  stored_in   = '0;
                  echo_bad_in = 1'b0;
               end
            end
            PH_END: begin
               has_result = 1'b1;
               if (rx_byte == END_BYTE) begin
                  entry.first = make_good(stored_ff);
                  phase_in    = PH_HUNT;
               end else begin
                  phase_in    = PH_HUNT;
                  stored_in   = '0;
                  echo_bad_in = 1'b0;
               end
            end
            default: begin
               has_result  = 1'b1;
               phase_in    = PH_HUNT;
               stored_in   = '0;
               echo_bad_in = 1'b0;
            end
         endcase
      end
   end

   assign entry_push = accept && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         prev_phase_ff  <= PH_HUNT;
         length_high_ff <= '0;
         length_low_ff  <= '0;
         remaining_ff   <= '0;
         stored_ff      <= '0;
         stall_ff       <= '0;
         echo_bad_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         prev_phase_ff  <= prev_phase_in;
         length_high_ff <= length_high_in;
         length_low_ff  <= length_low_in;
         remaining_ff   <= remaining_in;
         stored_ff      <= stored_in;
         stall_ff       <= stall_in;
         echo_bad_ff    <= echo_bad_in;
      end
   end

endmodule

[rtl/ldd_queue.sv]
module ldd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  ldd_pkg::entry_type wr_entry,
   output logic               full,
   input  logic               rd_en,
   output ldd_pkg::entry_type rd_entry,
   output logic               rd_valid
);
   import ldd_pkg::*;

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                do_wr, do_rd;

   assign full     = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_entry = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) count_in = count_ff + (QUEUE_AW+1)'(1);
      if (!do_wr && do_rd) count_in = count_ff - (QUEUE_AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (do_wr) slot_ff[wr_ptr_ff] <= wr_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/ldd_back.sv]
module ldd_back (
   input  logic               clock,
   input  logic               reset,
   input  ldd_pkg::entry_type q_entry,
   input  logic               q_valid,
   output logic               q_pop,
   output logic               empty,
   input  logic               pop,
   output logic [1:0]         kind,
   output logic [7:0]         data_byte,
   output logic [16:0]        frame_length,
   output logic               last
);
   import ldd_pkg::*;

   entry_type  hold_ff, hold_in;
   logic       valid_ff, valid_in;
   logic       idx_ff, idx_in;
   result_type cur;
   logic       take_out, done;

   assign cur          = idx_ff ? hold_ff.second : hold_ff.first;
   assign kind         = cur.kind;
   assign data_byte    = cur.data_byte;
   assign frame_length = cur.frame_length;
   assign last         = (idx_ff == hold_ff.pair);
   assign empty        = !valid_ff;

   assign take_out = valid_ff && pop;
   assign done     = take_out && last;
   assign q_pop    = q_valid && (!valid_ff || done);

   always_comb begin
      hold_in  = hold_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (take_out && !last) begin
         idx_in = 1'b1;
      end else if (q_pop) begin
         hold_in  = q_entry;
         valid_in = 1'b1;
         idx_in   = 1'b0;
      end else if (done) begin
         valid_in = 1'b0;
         idx_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

[rtl/length_framed_byte_deframer_top.sv]
// Length-framed byte deframer.
// Input queue port: present a word (req_opcode, req_rx_byte) with push; it is
// taken on a clock edge where push is high and full is low. Opcode 0 carries a
// received byte, opcode 1 a watchdog tick.
// Result queue port: while empty is low the oldest result word sits on the
// rsp_ ports; pop takes it. A byte may cause zero, one or two result words;
// rsp_last marks the final word caused by one input word.
// A result word passes through the queue and then the output stage's hold register
// before it is visible. One input word per cycle is taken while full is low; the
// parser's next state is combinational. Output drains one word per cycle while pop
// is high, so an input that causes two words holds the result side until both pop.
// A four-entry queue sits between the parser and the output stage; when the
// receiver stops popping, the queue fills and full rises, stalling the input.
// Config registers via the APB port: 0x0 length limit, 0x4 stall limit.
// Write only while idle. Reset (synchronous) empties the queue, returns the
// parser to start-byte hunt and loads the limits with 3000 and 10.
module length_framed_byte_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_opcode,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [16:0] rsp_frame_length,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ldd_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_sel;
   logic          csr_write;
   logic          accept;
   logic          entry_push;
   entry_type     entry, q_entry;
   logic          q_valid, q_pop;

   assign pready    = 1'b1;
   assign reg_sel   = reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_LENGTH_LIMIT: cfg_in.length_limit = pwdata[15:0];
            REG_STALL_LIMIT:  cfg_in.stall_limit  = pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_LENGTH_LIMIT: prdata = {16'd0, cfg_ff.length_limit};
         REG_STALL_LIMIT:  prdata = {24'd0, cfg_ff.stall_limit};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.length_limit <= LIMIT_RESET;
         cfg_ff.stall_limit  <= STALL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign accept = push && !full;

   ldd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .opcode     (req_opcode),
      .rx_byte    (req_rx_byte),
      .entry_push (entry_push),
      .entry      (entry)
   );

   ldd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (entry_push),
      .wr_entry (entry),
      .full     (full),
      .rd_en    (q_pop),
      .rd_entry (q_entry),
      .rd_valid (q_valid)
   );

   ldd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_entry      (q_entry),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .empty        (empty),
      .pop          (pop),
      .kind         (rsp_kind),
      .data_byte    (rsp_data_byte),
      .frame_length (rsp_frame_length),
      .last         (rsp_last)
   );

endmodule

[tb/sv/length_framed_byte_deframer_top_test.sv]
module length_framed_byte_deframer_top_test;
   import ldd_pkg::*;

   localparam logic OP_BYTE       = 1'b0;
   localparam logic OP_TICK       = 1'b1;
   localparam int   SETTLE_CYCLES = 8;
   localparam int   WORD_TARGET   = 1400;
   localparam int   PHASE_COUNT   = 6;
   localparam int   HOLD_CYCLES   = 300;

   typedef enum logic [2:0] {
      HUNT       = 3'd0,
      LEN_HIGH   = 3'd1,
      LEN_LOW    = 3'd2,
      PAYLOAD    = 3'd3,
      TERMINATOR = 3'd4
   } parse_phase_type;

   typedef struct {
      result_type word;
      logic       last;
   } rsp_word_type;

   class deframer_scoreboard;
      logic [15:0]     length_limit;
      logic [7:0]      stall_limit;
      parse_phase_type phase;
      parse_phase_type prev_phase;
      logic [7:0]      len_high;
      logic [7:0]      len_low;
      logic [7:0]      stall_ticks;
      logic [15:0]     remaining;
      logic [16:0]     stored;
      bit              echo_bad;
      rsp_word_type    expected_words[$];
      int              error_count;

      function new();
         length_limit = LIMIT_RESET;
         stall_limit  = STALL_RESET;
         phase        = HUNT;
         prev_phase   = HUNT;
         len_high     = '0;
         len_low      = '0;
         stall_ticks  = '0;
         remaining    = '0;
         stored       = '0;
         echo_bad     = 1'b0;
         error_count  = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [31:0] value);
         if (idx == REG_LENGTH_LIMIT) begin
            length_limit = value[15:0];
         end else begin
            stall_limit = value[7:0];
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void emit(kind_type k, logic [7:0] d, logic [16:0] n);
         rsp_word_type w;
         w.word.kind         = k;
         w.word.data_byte    = d;
         w.word.frame_length = n;
         w.last              = 1'b0;
         expected_words.push_back(w);
      endfunction

      function void drop_frame();
         phase    = HUNT;
         stored   = '0;
         echo_bad = 1'b0;
         emit(KIND_DROP, 8'd0, 17'd0);
      endfunction

      function void note_word(logic op, logic [7:0] b);
         int before_count;
         before_count = expected_words.size();
         if (op == OP_TICK) begin
            if (phase != HUNT && phase == prev_phase) begin
               if (stall_ticks != 8'hFF) stall_ticks++;
               if (stall_ticks > stall_limit) drop_frame();
            end else begin
               stall_ticks = '0;
               prev_phase  = phase;
            end
         end else begin
            case (phase)
               HUNT: begin
                  if (b == START_BYTE) phase = LEN_HIGH;
               end
               LEN_HIGH: begin
                  len_high = b;
                  phase    = LEN_LOW;
               end
               LEN_LOW: begin
                  len_low   = b;
                  remaining = {len_high, len_low};
                  stored    = 17'd2;
                  echo_bad  = 1'b0;
                  phase     = PAYLOAD;
                  emit(KIND_DATA, len_high, 17'd0);
                  emit(KIND_DATA, len_low, 17'd0);
               end
               PAYLOAD: begin
                  if (remaining != 0 && remaining < length_limit) begin
                     remaining--;
                     stored++;
                     emit(KIND_DATA, b, 17'd0);
                     if (remaining == 0) phase = TERMINATOR;
                     if (stored == ECHO_POS - 17'd1) echo_bad = (b != len_high);
                     if (stored == ECHO_POS && (echo_bad || b != len_low)) drop_frame();
                  end else begin
                     drop_frame();
                  end
               end
               TERMINATOR: begin
                  if (b == END_BYTE) begin
                     emit(KIND_GOOD, 8'd0, stored);
                     phase = HUNT;
                  end else begin
                     drop_frame();
                  end
               end
               default: begin
                  drop_frame();
               end
            endcase
         end
         if (expected_words.size() > before_count) begin
            expected_words[expected_words.size() - 1].last = 1'b1;
         end
      endfunction

      function void compare(string field, logic [16:0] want, logic [16:0] got);
         if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         end
      endfunction

      function void check_word(logic [1:0] kind, logic [7:0] data, logic [16:0] len,
                               logic last);
         rsp_word_type w;
         if (expected_words.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word, expected none actual kind %0d data %0d length %0d",
                     $time, kind, data, len);
            return;
         end
         w = expected_words.pop_front();
         compare("kind", w.word.kind, kind);
         compare("data_byte", w.word.data_byte, data);
         compare("frame_length", w.word.frame_length, len);
         compare("last", w.last, last);
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        push        = 1'b0;
   logic        req_opcode  = 1'b0;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        pop         = 1'b0;
   logic        psel        = 1'b0;
   logic        penable     = 1'b0;
   logic        pwrite      = 1'b0;
   logic [2:0]  paddr       = 3'd0;
   logic [31:0] pwdata      = 32'd0;
   logic        full;
   logic        empty;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [16:0] rsp_frame_length;
   logic        rsp_last;
   logic [31:0] prdata;
   logic        pready;

   deframer_scoreboard board;
   bit steady       = 1'b0;
   bit hold_request = 1'b0;
   int words_sent   = 0;
   int noise_sent   = 0;

   length_framed_byte_deframer_top dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_opcode       (req_opcode),
      .req_rx_byte      (req_rx_byte),
      .empty            (empty),
      .pop              (pop),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #5 clock = ~clock;

   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) begin
            board.check_word(rsp_kind, rsp_data_byte, rsp_frame_length, rsp_last);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= steady || ($urandom_range(99) >= 12);
         end
      end
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_word(logic op, logic [7:0] b);
      if (!steady && $urandom_range(99) < 12) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push        <= 1'b1;
      req_opcode  <= op;
      req_rx_byte <= b;
      do @(posedge clock); while (full);
      board.note_word(op, b);
      words_sent++;
   endtask

   task automatic drain();
      push <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      logic [31:0] mask;
      mask = (idx == REG_LENGTH_LIMIT) ? 32'h0000_FFFF : 32'h0000_00FF;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_reg(idx, value);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if ((prdata & mask) !== (value & mask)) begin
         board.error_count++;
         $display("%0t: register %0d readback mismatch, expected %0d actual %0d",
                  $time, idx, value & mask, prdata & mask);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic configure(logic [15:0] len_lim, logic [7:0] stall_lim);
      drain();
      write_reg(REG_LENGTH_LIMIT, {16'd0, len_lim});
      write_reg(REG_STALL_LIMIT, {24'd0, stall_lim});
   endtask

   // abort any open frame and a fresh one by the watchdog, then open another and give it one tick
   task automatic stall_out();
      while (board.phase != HUNT) send_word(OP_TICK, 8'($urandom));
      send_word(OP_BYTE, START_BYTE);
      while (board.phase != HUNT) send_word(OP_TICK, 8'($urandom));
      send_word(OP_BYTE, START_BYTE);
      send_word(OP_TICK, 8'($urandom));
   endtask

   task automatic send_frame();
      logic [15:0] len;
      logic [7:0]  b;
      int          count;
      bit          echo;
      while (board.phase == PAYLOAD && board.remaining > 16'd40) begin
         send_word(OP_TICK, 8'($urandom));
      end
      repeat ($urandom_range(3) == 0 ? $urandom_range(3, 1) : 0) begin
         send_word(OP_BYTE, 8'($urandom));
         noise_sent++;
      end
      case ($urandom_range(19))
         0:       len = 16'd0;
         1:       len = 16'($urandom_range(65535, board.length_limit));
         2, 3:    len = 16'($urandom_range(40, 4));
         default: len = 16'($urandom_range(8, 1));
      endcase
      count = (len == 0 || len >= board.length_limit) ? 1 : len;
      echo  = $urandom_range(3) != 0;
      send_word(OP_BYTE, START_BYTE);
      send_word(OP_BYTE, len[15:8]);
      send_word(OP_BYTE, len[7:0]);
      for (int i = 0; i < count; i++) begin
         b = 8'($urandom);
         if (echo && i == 2) b = len[15:8];
         if (echo && i == 3) b = len[7:0];
         if ($urandom_range(15) == 0) send_word(OP_TICK, 8'($urandom));
         send_word(OP_BYTE, b);
      end
      b = ($urandom_range(9) != 0) ? END_BYTE : 8'($urandom);
      send_word(OP_BYTE, b);
   endtask

   initial begin
      logic [7:0]  opening [] = '{8'h00,
                                  8'hF4, 8'h00, 8'h04, 8'h11, 8'h22, 8'h00, 8'h04, 8'hF5,
                                  8'hF4, 8'h00, 8'h04, 8'h33, 8'h44, 8'h00, 8'h05,
                                  8'hF4, 8'h00, 8'h00, 8'hFF,
                                  8'hF4, 8'h0B, 8'hB8, 8'h12};
      logic [15:0] len_lims [PHASE_COUNT];
      logic [7:0]  stall_lims [PHASE_COUNT];
      int          start;
      len_lims   = '{16'd3000, 16'd65535, 16'd1, 16'd9, 16'd20, 16'($urandom_range(65535, 1))};
      stall_lims = '{8'd10, 8'd254, 8'd0, 8'd3, 8'd1, 8'($urandom_range(254, 0))};
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (opening[i]) send_word(OP_BYTE, opening[i]);
      for (int p = 0; p < PHASE_COUNT; p++) begin
         configure(len_lims[p], stall_lims[p]);
         stall_out();
         if (p == 1) hold_request = 1'b1;
         steady = (p == 3);
         start  = words_sent - noise_sent;
         while (words_sent - noise_sent - start < WORD_TARGET / PHASE_COUNT) send_frame();
         steady = 1'b0;
      end
      drain();
      if (board.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
